// ===== src/msort_pkg.sv =====
package msort_pkg;

  // Sequencer step addresses
  typedef enum logic [3:0] {
    ST_LOAD    = 4'd0,
    ST_PINIT   = 4'd1,
    ST_PCHK    = 4'd2,
    ST_RINIT   = 4'd3,
    ST_SEG     = 4'd4,
    ST_SEGSET  = 4'd5,
    ST_MCHK    = 4'd6,
    ST_READ    = 4'd7,
    ST_MERGE   = 4'd8,
    ST_SEGNXT  = 4'd9,
    ST_PEND    = 4'd10,
    ST_EMINIT  = 4'd11,
    ST_EMRD    = 4'd12,
    ST_EMOUT   = 4'd13,
    ST_EMNXT   = 4'd14,
    ST_DONE    = 4'd15
  } upc_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PINIT,
    OP_RINIT,
    OP_SEGSET,
    OP_READ,
    OP_MERGE,
    OP_SEGNXT,
    OP_PEND,
    OP_EMINIT,
    OP_EMRD,
    OP_EMNXT,
    OP_DONE
  } uop_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_LOAD_WAIT,
    C_PASS_DONE,
    C_LO_DONE,
    C_SEG_DONE,
    C_OUT_WAIT,
    C_EMIT_MORE
  } cond_t;

  // One control word
  typedef struct packed {
    logic  in_rdy;
    logic  out_vld;
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } ucw_t;

  // Control store: jump to target when cond holds, else fall through
  function automatic ucw_t uc_rom(input upc_t pc);
    ucw_t w;
    w = '{in_rdy: 1'b0, out_vld: 1'b0, op: OP_NONE, cond: C_NEVER, target: ST_LOAD};
    unique case (pc)
      ST_LOAD:   w = '{1'b1, 1'b0, OP_LOAD,   C_LOAD_WAIT, ST_LOAD};
      ST_PINIT:  w = '{1'b0, 1'b0, OP_PINIT,  C_NEVER,     ST_LOAD};
      ST_PCHK:   w = '{1'b0, 1'b0, OP_NONE,   C_PASS_DONE, ST_EMINIT};
      ST_RINIT:  w = '{1'b0, 1'b0, OP_RINIT,  C_NEVER,     ST_LOAD};
      ST_SEG:    w = '{1'b0, 1'b0, OP_NONE,   C_LO_DONE,   ST_PEND};
      ST_SEGSET: w = '{1'b0, 1'b0, OP_SEGSET, C_NEVER,     ST_LOAD};
      ST_MCHK:   w = '{1'b0, 1'b0, OP_NONE,   C_SEG_DONE,  ST_SEGNXT};
      ST_READ:   w = '{1'b0, 1'b0, OP_READ,   C_NEVER,     ST_LOAD};
      ST_MERGE:  w = '{1'b0, 1'b0, OP_MERGE,  C_ALWAYS,    ST_MCHK};
      ST_SEGNXT: w = '{1'b0, 1'b0, OP_SEGNXT, C_ALWAYS,    ST_SEG};
      ST_PEND:   w = '{1'b0, 1'b0, OP_PEND,   C_ALWAYS,    ST_PCHK};
      ST_EMINIT: w = '{1'b0, 1'b0, OP_EMINIT, C_NEVER,     ST_LOAD};
      ST_EMRD:   w = '{1'b0, 1'b0, OP_EMRD,   C_NEVER,     ST_LOAD};
      ST_EMOUT:  w = '{1'b0, 1'b1, OP_NONE,   C_OUT_WAIT,  ST_EMOUT};
      ST_EMNXT:  w = '{1'b0, 1'b0, OP_EMNXT,  C_EMIT_MORE, ST_EMRD};
      ST_DONE:   w = '{1'b0, 1'b0, OP_DONE,   C_ALWAYS,    ST_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== src/merge_sort_engine_core.sv =====
// Channel | Ports                                  | Transaction
// --------+----------------------------------------+-------------------------------
// input   | in_valid, in_ready, in_value, in_last  | one value; in_last closes run
// output  | out_valid, out_ready, out_value,       | one sorted value, ascending;
//         | out_last, out_overflow                 | out_last on the final one
//
// Loading accepts one value per cycle while in_valid is high; in_ready is
// high only while collecting. The sort runs ceil(log2(n)) merge passes,
// ping-ponging between two RAMs; each output word of a pass is a check,
// read and compare/write step on the shared read ports. Emitting reads,
// outputs and advances for each value, holding while out_ready is low.
// rst_n (synchronous) clears the sequencer, count and overflow flag; the
// RAMs are not cleared, as only entries written in the current run are read.
module merge_sort_engine_core #(
  parameter int DEPTH       = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic                          out_last,
  output logic                          out_overflow
);

  import msort_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + 3;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Sequencer
  upc_t upc_r, upc_nxt;
  ucw_t ucw;
  logic jump;

  // Datapath registers
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          src_r, src_nxt;
  logic [EW-1:0] w_r, w_nxt;
  logic [EW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;

  // Derived values
  logic [EW-1:0] n_ext;
  logic [EW-1:0] lo_w;
  logic [EW-1:0] lo_2w;
  logic [EW-1:0] k_inc;
  logic          in_acc;
  logic          take_i;

  // RAM signals
  logic                   we_a, we_b, re;
  logic [AW-1:0]          waddr, raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
  logic [VALUE_WIDTH-1:0] src0, src1;

  assign ucw    = uc_rom(upc_r);
  assign in_acc = in_valid && ucw.in_rdy;
  assign n_ext  = EW'(cnt_r);
  assign lo_w   = lo_r + w_r;
  assign lo_2w  = lo_r + (w_r << 1);
  assign k_inc  = EW'(k_r) + EW'(1);

  // Jump condition
  always_comb begin
    unique case (ucw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_LOAD_WAIT: jump = !(in_valid && in_last);
      C_PASS_DONE: jump = (w_r >= n_ext);
      C_LO_DONE:   jump = (lo_r >= n_ext);
      C_SEG_DONE:  jump = (k_r >= hi_r);
      C_OUT_WAIT:  jump = !out_ready;
      C_EMIT_MORE: jump = (k_inc < n_ext);
      default:     jump = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (jump) begin
      upc_nxt = ucw.target;
    end else begin
      upc_nxt = upc_t'(upc_r + 4'd1);
    end
  end

  // Merge source data and choice (stable: left wins ties)
  assign src0   = src_r ? rd_b0 : rd_a0;
  assign src1   = src_r ? rd_b1 : rd_a1;
  assign take_i = (i_r < mid_r) &&
                  ((j_r >= hi_r) || ($signed(src0) <= $signed(src1)));

  // Datapath control
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    src_nxt = src_r;
    w_nxt   = w_r;
    lo_nxt  = lo_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    mid_nxt = mid_r;
    hi_nxt  = hi_r;
    we_a    = 1'b0;
    we_b    = 1'b0;
    re      = 1'b0;
    waddr   = k_r[AW-1:0];
    wdata   = take_i ? src0 : src1;
    raddr_a = i_r[AW-1:0];
    raddr_b = j_r[AW-1:0];
    unique case (ucw.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        waddr = cnt_r[AW-1:0];
        wdata = in_value;
        if (in_acc) begin
          if (cnt_r < DEPTH_C) begin
            we_a    = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      OP_PINIT: begin
        w_nxt   = EW'(1);
        src_nxt = 1'b0;
      end
      OP_RINIT: begin
        lo_nxt = '0;
      end
      OP_SEGSET: begin
        i_nxt   = lo_r[CW-1:0];
        k_nxt   = lo_r[CW-1:0];
        mid_nxt = (lo_w < n_ext) ? lo_w[CW-1:0] : cnt_r;
        j_nxt   = (lo_w < n_ext) ? lo_w[CW-1:0] : cnt_r;
        hi_nxt  = (lo_2w < n_ext) ? lo_2w[CW-1:0] : cnt_r;
      end
      OP_READ: begin
        re = 1'b1;
      end
      OP_MERGE: begin
        we_a  = src_r;
        we_b  = !src_r;
        k_nxt = k_r + CW'(1);
        if (take_i) begin
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      OP_SEGNXT: begin
        lo_nxt = lo_2w;
      end
      OP_PEND: begin
        w_nxt   = w_r << 1;
        src_nxt = !src_r;
      end
      OP_EMINIT: begin
        k_nxt = '0;
      end
      OP_EMRD: begin
        re      = 1'b1;
        raddr_a = k_r[AW-1:0];
      end
      OP_EMNXT: begin
        k_nxt = k_r + CW'(1);
      end
      OP_DONE: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_LOAD;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      src_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      src_r <= src_nxt;
    end
  end

  // Index registers
  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
  end

  // Ping-pong stores: bank A holds the loaded run
  msort_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .we      (we_a),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a0),
    .rdata_b (rd_a1)
  );

  msort_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .we      (we_b),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_b0),
    .rdata_b (rd_b1)
  );

  // Ports
  assign in_ready     = ucw.in_rdy;
  assign out_valid    = ucw.out_vld;
  assign out_value    = src0;
  assign out_last     = (k_inc == n_ext);
  assign out_overflow = ovf_r;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output handshakes enabled together");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("element count beyond store depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0) && (k_r < cnt_r))
    else $error("emitting from an empty or exhausted run");

  a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ST_MERGE) |-> (k_r < hi_r) && (i_r <= mid_r) && (j_r <= hi_r))
    else $error("merge indices out of segment");

  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> ##2 (in_ready && cnt_r == '0 && !ovf_r))
    else $error("run did not restart after final value");

endmodule

// ===== src/msort_ram.sv =====
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH  = 32;
  localparam int TARGET_ITEMS = 130;
  localparam int TAIL_ITEMS   = 20;   // no idling once this few items remain
  localparam int LONG_HOLD    = 300;  // receiver hold-off in cycles

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               wait_drain;  // offer only once every sorted word is back
  } run_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } sorted_word_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_value     = '0;
  logic               in_last      = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [31:0] out_value;
  logic               out_last;
  logic               out_overflow;

  run_item_t          stim_q [$];
  sorted_word_t       sorted_q [$];

  // current run as collected by the predictor
  logic signed [31:0] held_vals [$];
  logic               held_dropped = 1'b0;

  int unsigned items_built    = 0;
  int unsigned values_taken   = 0;
  int unsigned runs_closed    = 0;
  int unsigned runs_dropped   = 0;
  int unsigned words_checked  = 0;
  int unsigned errors         = 0;

  int unsigned tx_gap  = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_calm = 0;
  logic        long_hold_done = 1'b0;

  merge_sort_engine_core #(
    .DEPTH       (STORE_DEPTH),
    .VALUE_WIDTH (32)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Store one accepted value; on the closing value, sort the run stably and
  // queue the words the block should emit.
  task automatic take_value(input logic signed [31:0] v, input logic lst);
    logic signed [31:0] vals [$];
    logic signed [31:0] key;
    sorted_word_t       w;
    int                 i;
    int                 j;
    values_taken++;
    if (held_vals.size() < STORE_DEPTH) held_vals.push_back(v);
    else held_dropped = 1'b1;
    if (lst) begin
      vals = held_vals;
      // insertion sort: strict compare keeps equal values in arrival order
      for (i = 1; i < vals.size(); i++) begin
        key = vals[i];
        j   = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
      for (i = 0; i < vals.size(); i++) begin
        w.value = vals[i];
        w.last  = (i == vals.size() - 1);
        w.ovf   = held_dropped;
        sorted_q.push_back(w);
      end
      runs_closed++;
      if (held_dropped) runs_dropped++;
      held_vals.delete();
      held_dropped = 1'b0;
    end
  endtask

  task automatic add_item(input logic signed [31:0] v, input logic lst, input logic drain);
    run_item_t it;
    it.value      = v;
    it.last       = lst;
    it.wait_drain = drain;
    stim_q.push_back(it);
    items_built++;
  endtask

  // Sender: one transaction per accepted item, random gap bursts
  always @(posedge clk) begin : tx_proc
    run_item_t cur;
    logic      send_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
      in_last  <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_value(in_value, in_last);
      if (!in_valid || in_ready) begin
        send_now = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (stim_q.size() > 0 && !(stim_q[0].wait_drain && sorted_q.size() > 0)) begin
          if (tx_calm == 0 && stim_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            tx_gap  = $urandom_range(1, 16) - 1;
            tx_calm = $urandom_range(0, 30);
          end else begin
            if (tx_calm > 0) tx_calm--;
            cur      = stim_q.pop_front();
            in_value <= cur.value;
            in_last  <= cur.last;
            send_now = 1'b1;
          end
        end
        in_valid <= send_now;
      end
    end
  end

  // Receiver readiness: one long hold-off early on, then random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && out_valid && words_checked >= 10) begin
      long_hold_done = 1'b1;
      rx_hold        = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (rx_calm == 0 && stim_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(1, 16) - 1;
      rx_calm = $urandom_range(0, 40);
      out_ready <= 1'b0;
    end else begin
      if (rx_calm > 0) rx_calm--;
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each output transaction with the oldest queued word
  always @(posedge clk) begin : check_proc
    sorted_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got value %0d last %0b overflow %0b",
                 $time, out_value, out_last, out_overflow);
      end else begin
        want = sorted_q.pop_front();
        words_checked++;
        if (out_value !== want.value) begin
          errors++;
          $display("%0t: out_value expected %0d, got %0d", $time, want.value, out_value);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: out_last expected %0b, got %0b", $time, want.last, out_last);
        end
        if (out_overflow !== want.ovf) begin
          errors++;
          $display("%0t: out_overflow expected %0b, got %0b", $time, want.ovf,
                   out_overflow);
        end
      end
    end
  end

  initial begin
    int unsigned        run_idx;
    int unsigned        run_len;
    int unsigned        k;
    logic signed [31:0] v;

    // single value at the negative extreme
    add_item(32'sh8000_0000, 1'b1, 1'b0);
    // extremes, sign boundary, alternating bit patterns, repeated values
    add_item(32'sh7fff_ffff, 1'b0, 1'b0);
    add_item(32'sh8000_0000, 1'b0, 1'b0);
    add_item(32'sh0000_0000, 1'b0, 1'b0);
    add_item(32'shffff_ffff, 1'b0, 1'b0);
    add_item(32'sh0000_0001, 1'b0, 1'b0);
    add_item(32'sh7fff_ffff, 1'b0, 1'b0);
    add_item(32'sh5555_5555, 1'b0, 1'b0);
    add_item(32'shaaaa_aaaa, 1'b0, 1'b0);
    add_item(32'sh8000_0000, 1'b1, 1'b0);
    // all equal
    for (k = 0; k < 5; k++) add_item(32'sd7, (k == 4), 1'b0);
    // strictly descending
    for (k = 0; k < 4; k++) add_item(32'sd3 - k, (k == 3), 1'b0);

    // random runs; a full store, and one that overflows, mixed in
    run_idx = 0;
    while (items_built < TARGET_ITEMS) begin
      case (run_idx)
        1:       run_len = STORE_DEPTH;
        4:       run_len = STORE_DEPTH + 2;
        default: run_len = $urandom_range(1, 8);
      endcase
      for (k = 0; k < run_len; k++) begin
        case ($urandom_range(0, 7))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2, 3:    v = $signed($urandom_range(0, 6)) - 3;
          default: v = $urandom;
        endcase
        add_item(v, (k == run_len - 1), (k == 0 && run_idx % 5 == 0));
      end
      run_idx++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() > 0 || in_valid || sorted_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sorted_q.size() > 0) begin
      errors++;
      $display("%0t: %0d sorted words never arrived", $time, sorted_q.size());
    end
    $display("summary: %0d runs sorted (%0d with dropped values), %0d values taken in",
             runs_closed, runs_dropped, values_taken);
    $display("summary: %0d sorted words checked, %0d errors", words_checked, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
